>>> hdl/bva_pkg.sv
// Shared types, constants and helper functions for the bit-vector ALU.
// No dependencies; every other file of the block imports it.
package bva_pkg;

    localparam int DATA_W       = 64;
    localparam int SIZE_W       = 7;
    localparam int POS_W        = 8;
    localparam int OP_W         = 4;
    localparam int IDX_W        = $clog2(DATA_W);
    localparam int MAX_BITS_DEF = 64;

    // pipeline: decode, reduce, wrap, output
    localparam int NST = 4;

    // position magnitude reduction: one compare-subtract per quotient bit
    localparam int MOD_SPLIT = POS_W / 2;
    localparam int MODCMP_W  = SIZE_W + POS_W;

    // period doubling for the wrap window
    localparam int REP_STEPS = IDX_W;
    localparam int REP_SPLIT = REP_STEPS / 2;
    localparam int REP_SH_W  = SIZE_W + IDX_W;

    // config space
    localparam int                PADDR_W    = 2;
    localparam logic [PADDR_W-1:0] ADDR_VSIZE = PADDR_W'(0);
    localparam logic [SIZE_W-1:0]  VSIZE_RST  = SIZE_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_GET      = 4'd0,
        OP_SET      = 4'd1,
        OP_NOT      = 4'd2,
        OP_AND      = 4'd3,
        OP_OR       = 4'd4,
        OP_XOR      = 4'd5,
        OP_EXT_ZERO = 4'd6,
        OP_EXT_WRAP = 4'd7,
        OP_SHIFT    = 4'd8,
        OP_JOIN     = 4'd9
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [POS_W-1:0]   pos;
        logic [SIZE_W-1:0]  len;
        logic               val;
        logic [SIZE_W-1:0]  s;
        logic [DATA_W-1:0]  m;
        logic [POS_W-1:0]   u;
    } dec_t;

    typedef struct packed {
        logic               use_wrap;
        logic [DATA_W-1:0]  plain;
        logic [SIZE_W-1:0]  rlen;
        logic               ok;
        logic [DATA_W-1:0]  a;
        logic [SIZE_W-1:0]  s;
        logic [DATA_W-1:0]  m;
        logic [SIZE_W-1:0]  k;
    } red_t;

    typedef struct packed {
        logic               use_wrap;
        logic [DATA_W-1:0]  plain;
        logic [SIZE_W-1:0]  rlen;
        logic               ok;
        logic [DATA_W-1:0]  x;
        logic [SIZE_W-1:0]  s;
    } wrp_t;

    function automatic logic [DATA_W-1:0] low_mask(input logic [POS_W-1:0] n);
        logic [DATA_W-1:0] one_v;
        one_v = DATA_W'(1);
        if (n >= POS_W'(DATA_W))
            low_mask = '1;
        else
            low_mask = (one_v << n) - one_v;
    endfunction

    // one restoring step of |pos| mod s
    function automatic logic [POS_W-1:0] mod_step(input logic [POS_W-1:0] u,
                                                  input logic [SIZE_W-1:0] s,
                                                  input int j);
        logic [MODCMP_W-1:0] d;
        d = MODCMP_W'(s) << j;
        if (MODCMP_W'(u) >= d)
            mod_step = u - POS_W'(d);
        else
            mod_step = u;
    endfunction

    // x periodic over s*2^j bits -> periodic over s*2^(j+1) bits
    function automatic logic [DATA_W-1:0] rep_step(input logic [DATA_W-1:0] x,
                                                   input logic [SIZE_W-1:0] s,
                                                   input int j);
        logic [REP_SH_W-1:0] sh;
        sh = REP_SH_W'(s) << j;
        rep_step = x | (x << sh);
    endfunction

endpackage

>>> hdl/bva_decode.sv
// Stage 1: clamps size and length, masks operands, starts the position modulo.
// Depends on bva_pkg.
module bva_decode #(
    parameter int MAX_BITS = bva_pkg::MAX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [bva_pkg::OP_W-1:0]    opcode,
    input  logic [bva_pkg::DATA_W-1:0]  operand_a,
    input  logic [bva_pkg::DATA_W-1:0]  operand_b,
    input  logic signed [bva_pkg::POS_W-1:0] position,
    input  logic [bva_pkg::SIZE_W-1:0]  window_length,
    input  logic                        bit_value,
    input  logic [bva_pkg::SIZE_W-1:0]  vector_size,
    output bva_pkg::dec_t               dec_out
);
    import bva_pkg::*;

    dec_t              dec_reg;
    dec_t              dec_next;
    logic [SIZE_W-1:0] s;
    logic [DATA_W-1:0] m;
    logic [POS_W-1:0]  pos_u;
    logic [POS_W-1:0]  u;

    always_comb
    begin
        if (vector_size == '0)
            s = SIZE_W'(1);
        else if (vector_size > SIZE_W'(MAX_BITS))
            s = SIZE_W'(MAX_BITS);
        else
            s = vector_size;
        m     = low_mask(POS_W'(s));
        pos_u = position;
        u     = pos_u[POS_W-1] ? (~pos_u + POS_W'(1)) : pos_u;
        for (int j = POS_W - 1; j >= MOD_SPLIT; j--)
            u = mod_step(u, s, j);

        dec_next.op  = op_t'(opcode);
        dec_next.a   = operand_a & m;
        dec_next.b   = operand_b & m;
        dec_next.pos = pos_u;
        dec_next.len = (window_length > SIZE_W'(MAX_BITS)) ? SIZE_W'(MAX_BITS)
                                                            : window_length;
        dec_next.val = bit_value;
        dec_next.s   = s;
        dec_next.m   = m;
        dec_next.u   = u;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dec_reg <= dec_next;
    end

    assign dec_out = dec_reg;

endmodule

>>> hdl/bva_reduce.sv
// Stage 2: finishes the modulo for wrap, computes every non-wrap result.
// Depends on bva_pkg.
module bva_reduce (
    input  logic          clk,
    input  logic          en,
    input  bva_pkg::dec_t dec_in,
    output bva_pkg::red_t red_out
);
    import bva_pkg::*;

    red_t              red_reg;
    red_t              red_next;
    logic [POS_W-1:0]  u;
    logic              neg;
    logic [POS_W-1:0]  mag;
    logic              in_idx;
    logic [DATA_W-1:0] one_hot;
    logic [DATA_W-1:0] hi;

    always_comb
    begin
        u = dec_in.u;
        for (int j = MOD_SPLIT - 1; j >= 0; j--)
            u = mod_step(u, dec_in.s, j);
        neg     = dec_in.pos[POS_W-1];
        mag     = neg ? (~dec_in.pos + POS_W'(1)) : dec_in.pos;
        in_idx  = !neg && (dec_in.pos < POS_W'(dec_in.s));
        one_hot = DATA_W'(1) << dec_in.pos;
        hi      = dec_in.m & ~low_mask(dec_in.pos);

        red_next.use_wrap = 1'b0;
        red_next.plain    = '0;
        red_next.rlen     = dec_in.s;
        red_next.ok       = 1'b1;
        red_next.a        = dec_in.a;
        red_next.s        = dec_in.s;
        red_next.m        = dec_in.m;
        // mathematical modulo: negative start folds back from the top
        red_next.k        = (neg && u != '0) ? dec_in.s - SIZE_W'(u) : SIZE_W'(u);

        case (dec_in.op)
            OP_GET:
            begin
                red_next.rlen = SIZE_W'(1);
                if (in_idx)
                    red_next.plain = DATA_W'(dec_in.a[dec_in.pos[IDX_W-1:0]]);
                else
                    red_next.ok = 1'b0;
            end
            OP_SET:
            begin
                red_next.plain = dec_in.a;
                if (in_idx)
                    red_next.plain = (dec_in.a & ~one_hot) | (dec_in.val ? one_hot : '0);
                else
                    red_next.ok = 1'b0;
            end
            OP_NOT: red_next.plain = ~dec_in.a & dec_in.m;
            OP_AND: red_next.plain = dec_in.a & dec_in.b;
            OP_OR:  red_next.plain = dec_in.a | dec_in.b;
            OP_XOR: red_next.plain = dec_in.a ^ dec_in.b;
            OP_EXT_ZERO, OP_EXT_WRAP:
            begin
                if (dec_in.len == '0)
                begin
                    red_next.rlen = SIZE_W'(1);
                    red_next.ok   = 1'b0;
                end
                else
                begin
                    red_next.rlen = dec_in.len;
                    if (dec_in.op == OP_EXT_WRAP)
                        red_next.use_wrap = 1'b1;
                    else
                        red_next.plain = (neg ? dec_in.a << mag : dec_in.a >> dec_in.pos)
                                         & low_mask(POS_W'(dec_in.len));
                end
            end
            OP_SHIFT:
                red_next.plain = (neg ? dec_in.a >> mag : dec_in.a << dec_in.pos) & dec_in.m;
            OP_JOIN:
            begin
                if (neg || dec_in.pos > POS_W'(dec_in.s))
                    red_next.ok = 1'b0;
                else
                    red_next.plain = (dec_in.a & ~hi) | (dec_in.b & hi);
            end
            default: red_next.ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            red_reg <= red_next;
    end

    assign red_out = red_reg;

endmodule

>>> hdl/bva_wrap.sv
// Stage 3: rotates the vector by the reduced start, begins period doubling.
// Depends on bva_pkg.
module bva_wrap (
    input  logic          clk,
    input  logic          en,
    input  bva_pkg::red_t red_in,
    output bva_pkg::wrp_t wrp_out
);
    import bva_pkg::*;

    wrp_t              wrp_reg;
    wrp_t              wrp_next;
    logic [DATA_W-1:0] x;

    always_comb
    begin
        // rotate within the active size, then repeat with period s
        x = ((red_in.a >> red_in.k) | (red_in.a << (red_in.s - red_in.k))) & red_in.m;
        for (int j = 0; j < REP_SPLIT; j++)
            x = rep_step(x, red_in.s, j);
        wrp_next.use_wrap = red_in.use_wrap;
        wrp_next.plain    = red_in.plain;
        wrp_next.rlen     = red_in.rlen;
        wrp_next.ok       = red_in.ok;
        wrp_next.x        = x;
        wrp_next.s        = red_in.s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            wrp_reg <= wrp_next;
    end

    assign wrp_out = wrp_reg;

endmodule

>>> hdl/bva_output.sv
// Stage 4: finishes period doubling, selects the result, holds the output word.
// Depends on bva_pkg.
module bva_output (
    input  logic                        clk,
    input  logic                        en,
    input  bva_pkg::wrp_t               wrp_in,
    output logic [bva_pkg::DATA_W-1:0]  result_vector,
    output logic [bva_pkg::SIZE_W-1:0]  result_length,
    output logic                        ok
);
    import bva_pkg::*;

    logic [DATA_W-1:0] result_vector_reg;
    logic [SIZE_W-1:0] result_length_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] vec_next;

    always_comb
    begin
        x = wrp_in.x;
        for (int j = REP_SPLIT; j < REP_STEPS; j++)
            x = rep_step(x, wrp_in.s, j);
        vec_next = wrp_in.use_wrap ? (x & low_mask(POS_W'(wrp_in.rlen))) : wrp_in.plain;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_vector_reg <= vec_next;
            result_length_reg <= wrp_in.rlen;
            ok_reg            <= wrp_in.ok;
        end
    end

    assign result_vector = result_vector_reg;
    assign result_length = result_length_reg;
    assign ok            = ok_reg;

endmodule

>>> hdl/bit_vector_alu.sv
// Top level of the bit-vector ALU: config register, pipeline control, stages.
// Depends on bva_pkg, bva_decode, bva_reduce, bva_wrap, bva_output.
//
//  channel | valid        | stall        | word
//  --------+--------------+--------------+---------------------------------------------
//  item    | item_valid   | item_stall   | opcode operand_a operand_b position
//          |              |              | window_length bit_value
//  result  | result_valid | result_stall | result_vector result_length ok
//  config  | psel/penable | pready (=1)  | paddr pwrite pwdata prdata (vector_size @0)
//
// Four register stages (decode, reduce, wrap, output): one word per cycle while
// result_stall is low. An accepted item is registered by the stages in that order;
// result_valid rises once the output stage holds its result, taken when not stalled.
// Stages with no word collapse, so item_stall rises only when all four hold one.
// Reset clears the stage valid bits and sets vector_size to 64.
module bit_vector_alu #(
    parameter int MAX_BITS = bva_pkg::MAX_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bva_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [bva_pkg::OP_W-1:0]          opcode,
    input  logic [bva_pkg::DATA_W-1:0]        operand_a,
    input  logic [bva_pkg::DATA_W-1:0]        operand_b,
    input  logic signed [bva_pkg::POS_W-1:0]  position,
    input  logic [bva_pkg::SIZE_W-1:0]        window_length,
    input  logic                              bit_value,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [bva_pkg::DATA_W-1:0]        result_vector,
    output logic [bva_pkg::SIZE_W-1:0]        result_length,
    output logic                              ok
);
    import bva_pkg::*;

    logic [SIZE_W-1:0] vsize_reg;
    logic [NST-1:0]    valid_reg;
    logic [NST-1:0]    valid_next;
    logic [NST:0]      en;
    logic [NST-1:0]    upstream;
    logic              item_acc;
    logic              result_acc;

    dec_t dec_q;
    red_t red_q;
    wrp_t wrp_q;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_VSIZE) ? 32'(vsize_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vsize_reg <= VSIZE_RST;
        else if (psel && penable && pwrite && pready && paddr == ADDR_VSIZE)
            vsize_reg <= pwdata[SIZE_W-1:0];
    end

    // stage k loads when it is empty or its word moves on
    always_comb
    begin
        en[NST] = !result_stall;
        for (int k = NST - 1; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
        upstream = {valid_reg[NST-2:0], item_valid};
        for (int k = 0; k < NST; k++)
            valid_next[k] = en[k] ? upstream[k] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign item_stall   = !en[0];
    assign result_valid = valid_reg[NST-1];
    assign item_acc     = item_valid && !item_stall;
    assign result_acc   = result_valid && !result_stall;

    bva_decode #(
        .MAX_BITS (MAX_BITS)
    ) u_decode (
        .clk           (clk),
        .en            (en[0]),
        .opcode        (opcode),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .position      (position),
        .window_length (window_length),
        .bit_value     (bit_value),
        .vector_size   (vsize_reg),
        .dec_out       (dec_q)
    );

    bva_reduce u_reduce (
        .clk     (clk),
        .en      (en[1]),
        .dec_in  (dec_q),
        .red_out (red_q)
    );

    bva_wrap u_wrap (
        .clk     (clk),
        .en      (en[2]),
        .red_in  (red_q),
        .wrp_out (wrp_q)
    );

    bva_output u_output (
        .clk           (clk),
        .en            (en[3]),
        .wrp_in        (wrp_q),
        .result_vector (result_vector),
        .result_length (result_length),
        .ok            (ok)
    );

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (&valid_reg))
        else $error("item_stall with an empty stage");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + int'($past(item_acc)) - int'($past(result_acc))))
        else $error("word lost or duplicated in pipeline");

    a_wrap_start_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && red_q.use_wrap) |-> (red_q.k < red_q.s))
        else $error("wrap start not reduced below size");

    a_result_in_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result_vector & ~low_mask(POS_W'(result_length))) == '0))
        else $error("result bits above result_length");
`endif

endmodule
